/* hw/rtl/blh_pkg.sv */
// ----------------------------------------------------------------------------
// blh_pkg
// Shared types and constants for the battery level indicator with hysteresis.
// ----------------------------------------------------------------------------
package blh_pkg;

  localparam int unsigned MvWidth   = 13;
  localparam int unsigned HystWidth = 10;
  localparam int unsigned CfgIdxW   = 3;

  // Level codes as they appear on the result channel.
  typedef enum logic [2:0] {
    LV_UNKNOWN  = 3'd0,
    LV_CHARGING = 3'd1,
    LV_EMPTY    = 3'd2,
    LV_QUARTER  = 3'd3,
    LV_HALF     = 3'd4,
    LV_THREEQ   = 3'd5,
    LV_FULL     = 3'd6
  } level_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL    = 3'd0,
    CFG_THREEQ  = 3'd1,
    CFG_HALF    = 3'd2,
    CFG_QUARTER = 3'd3,
    CFG_EMPTY   = 3'd4,
    CFG_BAD     = 3'd5,
    CFG_HYST    = 3'd6
  } cfg_idx_e;

  localparam logic [MvWidth-1:0]   FullMvRst    = 13'd4000;
  localparam logic [MvWidth-1:0]   ThreeqMvRst  = 13'd3800;
  localparam logic [MvWidth-1:0]   HalfMvRst    = 13'd3600;
  localparam logic [MvWidth-1:0]   QuarterMvRst = 13'd3400;
  localparam logic [MvWidth-1:0]   EmptyMvRst   = 13'd3200;
  localparam logic [MvWidth-1:0]   BadMvRst     = 13'd2000;
  localparam logic [HystWidth-1:0] HystMvRst    = 10'd50;

  typedef struct packed {
    logic               charger_on;
    logic [MvWidth-1:0] battery_mv;
  } sample_t;

  typedef struct packed {
    logic [2:0] level_code;
  } level_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [MvWidth-1:0] data;
  } cfg_req_t;

  // Threshold register bank handed to the next-state logic.
  typedef struct packed {
    logic [MvWidth-1:0]   full_mv;
    logic [MvWidth-1:0]   three_quarter_mv;
    logic [MvWidth-1:0]   half_mv;
    logic [MvWidth-1:0]   quarter_mv;
    logic [MvWidth-1:0]   empty_mv;
    logic [MvWidth-1:0]   bad_mv;
    logic [HystWidth-1:0] hysteresis_mv;
  } thresholds_t;

endpackage

/* hw/rtl/blh_stream_if.sv */
// ----------------------------------------------------------------------------
// blh_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface blh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/blh_next_state.sv */
// ----------------------------------------------------------------------------
// blh_next_state
// Next level state from the current state, one sample and the thresholds.
// ----------------------------------------------------------------------------
module blh_next_state (
  input  blh_pkg::level_e      state_i,
  input  logic                 charger_on_i,
  input  logic [12:0]          battery_mv_i,
  input  blh_pkg::thresholds_t thr_i,
  output blh_pkg::level_e      state_o
);
  import blh_pkg::*;

  // Sums are one bit wider than a threshold, so a threshold plus the margin
  // never wraps. The lower test is rearranged as v + hyst < thr, which keeps
  // everything unsigned.
  localparam int unsigned SumW = MvWidth + 1;

  logic [SumW-1:0] v_ext;
  logic [SumW-1:0] h_ext;
  logic [SumW-1:0] v_plus_h;
  level_e          pick;

  function automatic logic above(input logic [SumW-1:0] v, input logic [SumW-1:0] h,
                                 input logic [MvWidth-1:0] thr);
    logic [SumW-1:0] lim;
    lim = {1'b0, thr} + h;
    return v > lim;
  endfunction

  function automatic logic below(input logic [SumW-1:0] vh,
                                 input logic [MvWidth-1:0] thr);
    return vh < {1'b0, thr};
  endfunction

  assign v_ext    = {1'b0, battery_mv_i};
  assign h_ext    = {{(SumW-HystWidth){1'b0}}, thr_i.hysteresis_mv};
  assign v_plus_h = v_ext + h_ext;

  // Plain strict-above selection, highest level first.
  always_comb begin
    if (battery_mv_i > thr_i.full_mv) begin
      pick = LV_FULL;
    end else if (battery_mv_i > thr_i.three_quarter_mv) begin
      pick = LV_THREEQ;
    end else if (battery_mv_i > thr_i.half_mv) begin
      pick = LV_HALF;
    end else if (battery_mv_i > thr_i.quarter_mv) begin
      pick = LV_QUARTER;
    end else if (battery_mv_i > thr_i.empty_mv) begin
      pick = LV_EMPTY;
    end else begin
      pick = LV_UNKNOWN;
    end
  end

  always_comb begin
    state_o = state_i;
    if (state_i == LV_CHARGING) begin
      if (!charger_on_i) state_o = pick;
    end else if (charger_on_i) begin
      state_o = LV_CHARGING;
    end else begin
      case (state_i)
        LV_FULL: begin
          if (below(v_plus_h, thr_i.three_quarter_mv)) state_o = LV_THREEQ;
        end
        LV_THREEQ: begin
          if (above(v_ext, h_ext, thr_i.full_mv)) state_o = LV_FULL;
          else if (below(v_plus_h, thr_i.half_mv)) state_o = LV_HALF;
        end
        LV_HALF: begin
          if (above(v_ext, h_ext, thr_i.three_quarter_mv)) state_o = LV_THREEQ;
          else if (below(v_plus_h, thr_i.quarter_mv)) state_o = LV_QUARTER;
        end
        LV_QUARTER: begin
          if (above(v_ext, h_ext, thr_i.half_mv)) state_o = LV_HALF;
          else if (below(v_plus_h, thr_i.empty_mv)) state_o = LV_EMPTY;
        end
        LV_EMPTY: begin
          if (above(v_ext, h_ext, thr_i.quarter_mv)) state_o = LV_QUARTER;
          else if (battery_mv_i < thr_i.bad_mv) state_o = LV_UNKNOWN;
        end
        default: begin
          state_o = pick;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/battery_level_hysteresis_fsm.sv */
// Pipeline: a request is registered in the input register on acceptance, and its
// level is registered into the result register when that register frees up.
// Throughput: one sample per cycle unless out_o stalls; the level state register
// is updated as a sample moves from the input register to the result register.
// Reset: state returns to unknown, thresholds to their default millivolt
// values, both pipeline registers empty.
// ----------------------------------------------------------------------------
// battery_level_hysteresis_fsm
// Battery level indicator with hysteresis: one level code per voltage sample.
// ----------------------------------------------------------------------------
module battery_level_hysteresis_fsm (
  input  logic         clk_i,
  input  logic         rst_ni,
  blh_stream_if.sink   in_i,
  blh_stream_if.source out_o,
  blh_stream_if.sink   cfg_i
);
  import blh_pkg::*;

  thresholds_t thr_q;
  cfg_req_t    cfg_req;
  sample_t     in_req;

  logic    s1_valid_q;
  sample_t s1_q;
  logic    out_valid_q;
  level_e  out_level_q;
  level_e  state_q;
  level_e  state_d;
  logic    advance;

  assign cfg_req     = cfg_i.payload;
  assign in_req      = in_i.payload;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.full_mv          <= FullMvRst;
      thr_q.three_quarter_mv <= ThreeqMvRst;
      thr_q.half_mv          <= HalfMvRst;
      thr_q.quarter_mv       <= QuarterMvRst;
      thr_q.empty_mv         <= EmptyMvRst;
      thr_q.bad_mv           <= BadMvRst;
      thr_q.hysteresis_mv    <= HystMvRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_req.index))
        CFG_FULL:    thr_q.full_mv          <= cfg_req.data;
        CFG_THREEQ:  thr_q.three_quarter_mv <= cfg_req.data;
        CFG_HALF:    thr_q.half_mv          <= cfg_req.data;
        CFG_QUARTER: thr_q.quarter_mv       <= cfg_req.data;
        CFG_EMPTY:   thr_q.empty_mv         <= cfg_req.data;
        CFG_BAD:     thr_q.bad_mv           <= cfg_req.data;
        CFG_HYST:    thr_q.hysteresis_mv    <= cfg_req.data[HystWidth-1:0];
        default: ;
      endcase
    end
  end

  // The result register frees up when it is empty or being taken this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_req;
    end
  end

  blh_next_state u_next (
    .state_i      (state_q),
    .charger_on_i (s1_q.charger_on),
    .battery_mv_i (s1_q.battery_mv),
    .thr_i        (thr_q),
    .state_o      (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LV_UNKNOWN;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_level_q <= state_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.payload.level_code = out_level_q;

`ifndef NO_ASSERTIONS
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_level_q == state_q))
    else $error("result register differs from the level state");

  a_charger_forces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_q.charger_on) |=> (state_q == LV_CHARGING))
    else $error("charger flag did not force the charging state");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("level state changed without a request");

  a_no_code_seven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> (state_d <= LV_FULL))
    else $error("next-state logic produced an unused code");
`endif

endmodule
